@@ hw/rtl/ffte_pkg.sv @@
// ffte_pkg: shared types and constants for the flat file table engine
// used by ffte_cell, ffte_cmap and flat_file_table_engine; no dependencies

package ffte_pkg;

    localparam int DIR_ENTRIES   = 16;
    localparam int CLUSTER_COUNT = 256;
    localparam int MAX_RESULTS   = 16;

    localparam int BASE_W   = 64;
    localparam int EXT_W    = 24;
    localparam int CL_W     = 8;
    localparam int SECTOR_W = 17;
    localparam int CFG_W    = 16;

    localparam int CHUNKS  = (CLUSTER_COUNT + 7) / 8;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int MAP_W   = CHUNK_W + 3;
    localparam int STEP_W  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0]       MARK_EMPTY   = 8'h00;
    localparam logic [7:0]       MARK_DELETED = 8'hE5;
    localparam logic [CFG_W-1:0] SECTOR_BASE_RESET = 16'd11;

    typedef enum logic [1:0] {
        OP_LIST   = 2'd0,
        OP_FIND   = 2'd1,
        OP_CREATE = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_NO_CLUSTER = 3'd2,
        ST_DIR_FULL   = 3'd3,
        ST_DIR_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_WAIT,
        S_ALLOC,
        S_SCAN,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXT_W-1:0]  ext;
        logic [CL_W-1:0]   cluster;
    } t_entry;

    typedef struct packed {
        t_status             status;
        logic [BASE_W-1:0]   base;
        logic [EXT_W-1:0]    ext;
        logic [CL_W-1:0]     cluster;
        logic [SECTOR_W-1:0] sector;
    } t_result;

    typedef struct packed {
        logic            set_en;
        logic            clr_en;
        logic [CL_W-1:0] idx;
    } t_cmap_req;

    typedef struct packed {
        logic            any_free;
        logic [CL_W-1:0] cluster;
    } t_cmap_stat;

endpackage

@@ hw/rtl/ffte_cell.sv @@
// ffte_cell: one directory entry cell of the rotating entry chain
// depends on ffte_pkg (t_entry)

module ffte_cell
    import ffte_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    // entry moves one place towards the head on each shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ hw/rtl/ffte_cmap.sv @@
// ffte_cmap: cluster-in-use map with a two-level first-free search
// depends on ffte_pkg (sizes, t_cmap_req, t_cmap_stat)

module ffte_cmap
    import ffte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmap_req  i_req,
    output t_cmap_stat o_stat
);

    logic [CHUNKS*8-1:0]  r_used;
    logic [CHUNKS*8-1:0]  free_vec;
    logic [CHUNKS-1:0]    chunk_free;
    logic [CHUNK_W-1:0]   n_chunk;
    logic [CHUNK_W-1:0]   r_chunk;
    logic                 n_any;
    logic                 r_any;
    logic [7:0]           chunk_bits;
    logic [2:0]           bit_idx;
    logic                 idx_ok;

    // clusters 0 and 1 and padding beyond the map never count as free
    always_comb begin
        for (int i = 0; i < CHUNKS * 8; i++) begin
            free_vec[i] = (i >= 2) && (i < CLUSTER_COUNT) && !r_used[i];
        end
        for (int c = 0; c < CHUNKS; c++) begin
            chunk_free[c] = |free_vec[c*8 +: 8];
        end
    end

    // first chunk with a free cluster
    always_comb begin
        n_chunk = '0;
        n_any   = 1'b0;
        for (int c = CHUNKS - 1; c >= 0; c--) begin
            if (chunk_free[c]) begin
                n_chunk = CHUNK_W'(c);
                n_any   = 1'b1;
            end
        end
    end

    // first free cluster inside the registered chunk
    always_comb begin
        chunk_bits = free_vec[r_chunk*8 +: 8];
        bit_idx    = '0;
        for (int b = 7; b >= 0; b--) begin
            if (chunk_bits[b]) begin
                bit_idx = 3'(b);
            end
        end
    end

    assign idx_ok = (32'(i_req.idx) < CLUSTER_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_chunk <= '0;
            r_any   <= 1'b0;
        end else begin
            r_chunk <= n_chunk;
            r_any   <= n_any;
            if (i_req.set_en && idx_ok) begin
                r_used[i_req.idx[MAP_W-1:0]] <= 1'b1;
            end else if (i_req.clr_en && idx_ok) begin
                r_used[i_req.idx[MAP_W-1:0]] <= 1'b0;
            end
        end
    end

    assign o_stat.any_free = r_any;
    assign o_stat.cluster  = CL_W'({r_chunk, bit_idx});

endmodule

@@ hw/rtl/flat_file_table_engine.sv @@
// flat_file_table_engine: root directory and cluster allocator, top level
// depends on ffte_pkg, ffte_cell (entry chain) and ffte_cmap (cluster map)

// usage
//   input channel: one command transaction (operation, 11-byte name) at a time;
//   o_in_ready is high only out of reset and while no command is in progress
//   output channel: result transactions; o_last marks the final one of a command
//   config channel: i_cfg_data writes the sector number of cluster 2; ready
//   whenever out of reset, write only while the engine is idle
// timing
//   the directory sits in a ring of DIR_ENTRIES cells that rotates once per
//   scanning command, one entry a cycle while no stalled list result holds it,
//   so such a command walks all 16 entries; find and delete scan, then load
//   the result in S_FINAL; create first takes S_ALLOC_WAIT and S_ALLOC (the
//   cluster map first-free search); list results stream out during the scan,
//   the final one from S_FINAL; a create with no free cluster skips the scan;
//   the next command is accepted the cycle after the final result is loaded
// reset
//   synchronous, active low: empty directory, all clusters free, base 11
// stalls
//   results wait in an output register; a stalled receiver holds the rotation
//   whenever a new list result has to go out

module flat_file_table_engine
    import ffte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_operation,
    input  logic [BASE_W-1:0]   i_name_base,
    input  logic [EXT_W-1:0]    i_name_ext,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_status,
    output logic [BASE_W-1:0]   o_entry_base,
    output logic [EXT_W-1:0]    o_entry_ext,
    output logic [CL_W-1:0]     o_start_cluster,
    output logic [SECTOR_W-1:0] o_data_sector,
    output logic                o_last,
    // configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    // sector of a cluster, zero below the first data cluster
    function automatic t_result entry_result(input t_entry e, input logic [CFG_W-1:0] sb);
        t_result res;
        res.status  = ST_OK;
        res.base    = e.base;
        res.ext     = e.ext;
        res.cluster = e.cluster;
        if (e.cluster < CL_W'(2)) begin
            res.sector = '0;
        end else begin
            res.sector = SECTOR_W'(sb) + SECTOR_W'(e.cluster) - SECTOR_W'(2);
        end
        return res;
    endfunction

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [BASE_W-1:0]   r_nb, n_nb;
    logic [EXT_W-1:0]    r_ne, n_ne;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_stop, n_stop;
    logic                r_hit, n_hit;
    logic                r_have, n_have;
    logic [CL_W-1:0]     r_alloc, n_alloc;
    t_result             r_pend, n_pend;
    logic [CFG_W-1:0]    r_sbase;

    logic                r_out_valid, n_out_valid;
    t_result             r_out;
    logic                r_out_last;

    logic                push, push_last, out_free;
    logic                shift;
    t_entry              wb;
    t_entry              head;
    t_entry              cell_in  [DIR_ENTRIES];
    t_entry              cell_out [DIR_ENTRIES];
    t_cmap_req           cmap_req;
    t_cmap_stat          cmap_stat;

    logic [7:0]          b0;
    logic                is_empty, is_del, live, match, stall;

    // ring of entry cells, cell 0 is the head under inspection
    for (genvar g = 0; g < DIR_ENTRIES; g++) begin : g_cell
        if (g == DIR_ENTRIES - 1) begin : g_tail
            assign cell_in[g] = wb;
        end else begin : g_mid
            assign cell_in[g] = cell_out[g+1];
        end
        ffte_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry (cell_in[g]),
            .o_entry (cell_out[g])
        );
    end

    assign head = cell_out[0];

    ffte_cmap u_cmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmap_req),
        .o_stat  (cmap_stat)
    );

    // head entry classification
    assign b0       = head.base[7:0];
    assign is_empty = (b0 == MARK_EMPTY);
    assign is_del   = (b0 == MARK_DELETED);
    assign live     = !r_stop && !is_empty && !is_del;
    assign match    = (head.base == r_nb) && (head.ext == r_ne);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_cfg_ready = i_rst_n;

    // a list result can only leave when the output register has room
    assign stall = (r_state == S_SCAN) && (r_op == OP_LIST) && live
                   && (r_cnt < CNT_W'(MAX_RESULTS)) && r_have && !out_free;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_nb      = r_nb;
        n_ne      = r_ne;
        n_step    = r_step;
        n_cnt     = r_cnt;
        n_stop    = r_stop;
        n_hit     = r_hit;
        n_have    = r_have;
        n_alloc   = r_alloc;
        n_pend    = r_pend;
        push      = 1'b0;
        push_last = 1'b0;
        shift     = 1'b0;
        wb        = head;
        cmap_req  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_operation);
                    n_nb    = i_name_base;
                    n_ne    = i_name_ext;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_stop  = 1'b0;
                    n_hit   = 1'b0;
                    n_have  = 1'b0;
                    n_pend  = '0;
                    // failure answer preloaded, replaced on a hit
                    if (t_op'(i_operation) == OP_LIST) begin
                        n_pend.status = ST_DIR_EMPTY;
                    end else begin
                        n_pend.status = ST_NOT_FOUND;
                    end
                    if (t_op'(i_operation) == OP_CREATE) begin
                        n_state = S_ALLOC_WAIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_ALLOC_WAIT: begin
                // chunk search register catches up with the last map update
                n_state = S_ALLOC;
            end
            S_ALLOC: begin
                if (cmap_stat.any_free) begin
                    n_alloc       = cmap_stat.cluster;
                    n_pend.status = ST_DIR_FULL;
                    n_state       = S_SCAN;
                end else begin
                    n_pend.status = ST_NO_CLUSTER;
                    n_state       = S_FINAL;
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    shift  = 1'b1;
                    n_step = r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIR_ENTRIES - 1)) begin
                        n_state = S_FINAL;
                    end
                    case (r_op)
                        OP_LIST: begin
                            if (live && (r_cnt < CNT_W'(MAX_RESULTS))) begin
                                if (r_have) begin
                                    push = 1'b1;
                                end
                                n_pend = entry_result(head, r_sbase);
                                n_have = 1'b1;
                                n_cnt  = r_cnt + CNT_W'(1);
                            end
                            if (is_empty) begin
                                n_stop = 1'b1;
                            end
                        end
                        OP_FIND, OP_DELETE: begin
                            if (live && !r_hit && match) begin
                                n_pend = entry_result(head, r_sbase);
                                n_hit  = 1'b1;
                                if (r_op == OP_DELETE) begin
                                    wb.base[7:0] = MARK_DELETED;
                                end
                            end
                            if (is_empty) begin
                                n_stop = 1'b1;
                            end
                        end
                        OP_CREATE: begin
                            // first empty or deleted slot, no stop at empty
                            if (!r_hit && (is_empty || is_del)) begin
                                wb.base    = r_nb;
                                wb.ext     = r_ne;
                                wb.cluster = r_alloc;
                                n_pend     = entry_result(wb, r_sbase);
                                n_hit      = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                    if (r_hit && (r_op == OP_CREATE)) begin
                        cmap_req.set_en = 1'b1;
                        cmap_req.idx    = r_alloc;
                    end
                    if (r_hit && (r_op == OP_DELETE)) begin
                        cmap_req.clr_en = 1'b1;
                        cmap_req.idx    = r_pend.cluster;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb begin
        if (push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_stop      <= 1'b0;
            r_hit       <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sbase     <= SECTOR_BASE_RESET;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_stop      <= n_stop;
            r_hit       <= n_hit;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_sbase <= i_cfg_data;
            end
        end
    end

    // command and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_nb    <= n_nb;
        r_ne    <= n_ne;
        r_alloc <= n_alloc;
        r_pend  <= n_pend;
        if (push) begin
            r_out      <= r_pend;
            r_out_last <= push_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_entry_base    = r_out.base;
    assign o_entry_ext     = r_out.ext;
    assign o_start_cluster = r_out.cluster;
    assign o_data_sector   = r_out.sector;
    assign o_last          = r_out_last;

endmodule
